### rtl/core/c3vs_pkg.sv
// ----------------------------------------------------------------------------
// c3vs_pkg
// Shared types and constants of the streaming 3x3 valid-mode convolution.
// ----------------------------------------------------------------------------
package c3vs_pkg;

  // fixed field widths of the register map and the result positions
  localparam int unsigned SideW    = 9;
  localparam int unsigned OutPosW  = 8;
  localparam int unsigned NumTaps  = 3;
  localparam int unsigned MinSide  = 3;
  localparam int unsigned SideRst  = 256;
  localparam int unsigned CfgIdxW  = 2;

  // center tap of the reset kernel, all other taps are minus one
  localparam int          LapCenter = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIDE      = 2'd0,
    CFG_COEF_ROW0 = 2'd1,
    CFG_COEF_ROW1 = 2'd2,
    CFG_COEF_ROW2 = 2'd3
  } cfg_idx_e;

  // position information that travels along with a result
  typedef struct packed {
    logic               last;
    logic [OutPosW-1:0] row;
    logic [OutPosW-1:0] col;
  } meta_t;

endpackage

### rtl/core/conv3x3_valid_stream.sv
// ----------------------------------------------------------------------------
// conv3x3_valid_stream
// Streaming 3x3 valid-mode convolution with two line buffers in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels of a square image enter on the in_* channel in row-major order,
//   one transaction per pixel; frame_start_i marks row 0, column 0. Every
//   pixel at row >= 2 and column >= 2 produces one result on the out_*
//   channel: the 3x3 sum for output position (row-2, col-2), with last_o set
//   on the final result of the frame. Other pixels produce no result.
//   Side and coefficients are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   while the block is idle.
// Timing:
//   A result passes the memory stage and the product, row-sum and output registers.
//   One pixel per cycle is sustained while results are taken; the limit is the
//   single line memory, which is read at the accept edge and written back as the
//   pixel leaves, with the write data forwarded when two neighbors hit the same column.
// Reset:
//   Counters and pipeline go empty and the registers take their reset values
//   (side 256, Laplacian kernel). The line memory is not cleared.
// Stall:
//   When out_ready_i is low the result is held in the output register; the
//   internal stages keep taking pixels until they are full, and pixels that
//   make no result keep flowing as long as the memory stage can drain.
// ----------------------------------------------------------------------------
module conv3x3_valid_stream #(
  parameter int unsigned MAX_SIDE   = 256,
  parameter int unsigned PIXEL_BITS = 16,
  parameter int unsigned COEF_BITS  = 8
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  // configuration
  input  logic                                           cfg_we_i,
  input  logic [c3vs_pkg::CfgIdxW-1:0]                   cfg_idx_i,
  input  logic [((c3vs_pkg::SideW > 3*COEF_BITS) ?
                 c3vs_pkg::SideW : 3*COEF_BITS)-1:0]     cfg_wdata_i,
  // pixel input
  input  logic                                           in_valid_i,
  output logic                                           in_ready_o,
  input  logic signed [PIXEL_BITS-1:0]                   pixel_i,
  input  logic                                           frame_start_i,
  // result output
  output logic                                           out_valid_o,
  input  logic                                           out_ready_i,
  output logic [c3vs_pkg::OutPosW-1:0]                   out_row_o,
  output logic [c3vs_pkg::OutPosW-1:0]                   out_col_o,
  output logic signed [PIXEL_BITS+COEF_BITS+2:0]         sum_o,
  output logic                                           last_o
);

  localparam int unsigned Taps     = c3vs_pkg::NumTaps;
  localparam int unsigned SideW    = c3vs_pkg::SideW;
  localparam int unsigned OutPosW  = c3vs_pkg::OutPosW;
  localparam int unsigned CoefRowW = Taps * COEF_BITS;
  localparam int unsigned PosW     = $clog2(MAX_SIDE);
  localparam int unsigned NW       = $clog2(MAX_SIDE + 1);
  localparam int unsigned CmpW     = ((NW > SideW) ? NW : SideW) + 1;
  localparam int unsigned RW       = (PosW > OutPosW) ? PosW : OutPosW;
  localparam int unsigned ProdW    = PIXEL_BITS + COEF_BITS;
  localparam int unsigned RsW      = ProdW + 2;
  localparam int unsigned TotW     = ProdW + 4;
  localparam int unsigned SumW     = ProdW + 3;
  localparam int unsigned MemW     = 2 * PIXEL_BITS;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [SideW-1:0]    side_q;
  logic [CoefRowW-1:0] coef_q [Taps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q    <= SideW'(c3vs_pkg::SideRst);
      coef_q[0] <= '1;
      coef_q[1] <= {COEF_BITS'(-1), COEF_BITS'(c3vs_pkg::LapCenter), COEF_BITS'(-1)};
      coef_q[2] <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c3vs_pkg::CFG_SIDE:      side_q    <= cfg_wdata_i[SideW-1:0];
        c3vs_pkg::CFG_COEF_ROW0: coef_q[0] <= cfg_wdata_i[CoefRowW-1:0];
        c3vs_pkg::CFG_COEF_ROW1: coef_q[1] <= cfg_wdata_i[CoefRowW-1:0];
        c3vs_pkg::CFG_COEF_ROW2: coef_q[2] <= cfg_wdata_i[CoefRowW-1:0];
        default: ;
      endcase
    end
  end

  // effective side, clamped to the supported range
  logic [CmpW-1:0] side_ext;
  logic [CmpW-1:0] n_c;

  always_comb begin
    side_ext = CmpW'(side_q);
    if (side_ext < CmpW'(c3vs_pkg::MinSide)) begin
      n_c = CmpW'(c3vs_pkg::MinSide);
    end else if (side_ext > CmpW'(MAX_SIDE)) begin
      n_c = CmpW'(MAX_SIDE);
    end else begin
      n_c = side_ext;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_emit_q;
  logic take_out, take_s3, take_s2, s1_go, in_acc;

  assign take_out   = !out_v_q || out_ready_i;
  assign take_s3    = !s3_v_q || take_out;
  assign take_s2    = !s2_v_q || take_s3;
  // pixels without a result leave the memory stage regardless of the output
  assign s1_go      = s1_v_q && (!s1_emit_q || take_s2);
  assign in_ready_o = !s1_v_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_v_q  <= in_valid_i;
      if (take_s2)    s2_v_q  <= s1_go && s1_emit_q;
      if (take_s3)    s3_v_q  <= s2_v_q;
      if (take_out)   out_v_q <= s3_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // position counters, evaluated at the accept edge
  // --------------------------------------------------------------------------
  logic [PosW-1:0] col_q, row_q;
  logic [PosW-1:0] col_now, row_now;
  logic            col_wrap, row_wrap, emit_c;
  c3vs_pkg::meta_t meta_c;
  logic [RW-1:0]   row_off, col_off;

  always_comb begin
    col_now  = frame_start_i ? '0 : col_q;
    row_now  = frame_start_i ? '0 : row_q;
    col_wrap = (CmpW'(col_now) + CmpW'(1)) >= n_c;
    row_wrap = (CmpW'(row_now) + CmpW'(1)) >= n_c;
    emit_c   = (row_now >= PosW'(2)) && (col_now >= PosW'(2));
    row_off  = RW'(row_now) - RW'(2);
    col_off  = RW'(col_now) - RW'(2);
    meta_c.row  = row_off[OutPosW-1:0];
    meta_c.col  = col_off[OutPosW-1:0];
    meta_c.last = (CmpW'(row_now) == n_c - CmpW'(1)) &&
                  (CmpW'(col_now) == n_c - CmpW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_now + PosW'(1);
      end else begin
        col_q <= col_now + PosW'(1);
        row_q <= row_now;
      end
    end
  end

  // --------------------------------------------------------------------------
  // line memory: entry holds {two rows up, one row up} of a column
  // --------------------------------------------------------------------------
  logic [MemW-1:0] mem_q [MAX_SIDE];
  logic [MemW-1:0] rd_q;
  logic [MemW-1:0] rd_eff;
  logic [MemW-1:0] wb_data;
  logic            fwd_q;
  logic [MemW-1:0] fwd_data_q;

  logic signed [PIXEL_BITS-1:0] s1_px_q;
  logic [PosW-1:0]              s1_col_q;
  c3vs_pkg::meta_t              s1_meta_q;

  assign rd_eff  = fwd_q ? fwd_data_q : rd_q;
  assign wb_data = {rd_eff[PIXEL_BITS-1:0], s1_px_q};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= mem_q[col_now];
    end
    if (s1_go) begin
      mem_q[s1_col_q] <= wb_data;
    end
  end

  // the pixel ahead writes back at the same edge: take its data directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_acc) begin
      fwd_q <= s1_v_q && (s1_col_q == col_now);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= wb_data;
      s1_px_q    <= pixel_i;
      s1_col_q   <= col_now;
      s1_meta_q  <= meta_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_emit_q <= 1'b0;
    end else if (in_acc) begin
      s1_emit_q <= emit_c;
    end
  end

  // --------------------------------------------------------------------------
  // window shift and products
  // --------------------------------------------------------------------------
  logic signed [PIXEL_BITS-1:0] win_q [Taps][Taps];
  logic signed [PIXEL_BITS-1:0] win_d [Taps][Taps];
  logic signed [COEF_BITS-1:0]  coef_s [Taps][Taps];
  logic signed [ProdW-1:0]      prod_d [Taps*Taps];

  always_comb begin
    for (int r = 0; r < Taps; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
      for (int k = 0; k < Taps; k++) begin
        coef_s[r][k] = coef_q[r][COEF_BITS*k +: COEF_BITS];
      end
    end
    win_d[0][2] = rd_eff[MemW-1:PIXEL_BITS];
    win_d[1][2] = rd_eff[PIXEL_BITS-1:0];
    win_d[2][2] = s1_px_q;
    for (int r = 0; r < Taps; r++) begin
      for (int k = 0; k < Taps; k++) begin
        prod_d[r*Taps+k] = win_d[r][k] * coef_s[r][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Taps; r++) begin
        for (int k = 0; k < Taps; k++) begin
          win_q[r][k] <= '0;
        end
      end
    end else if (s1_go) begin
      win_q <= win_d;
    end
  end

  // --------------------------------------------------------------------------
  // adder stages and output register
  // --------------------------------------------------------------------------
  logic signed [ProdW-1:0] prod_q [Taps*Taps];
  logic signed [RsW-1:0]   rsum_q [Taps];
  logic signed [TotW-1:0]  total_c;
  logic signed [SumW-1:0]  sum_q;
  c3vs_pkg::meta_t         s2_meta_q, s3_meta_q, out_meta_q;

  assign total_c = TotW'(rsum_q[0]) + TotW'(rsum_q[1]) + TotW'(rsum_q[2]);

  always_ff @(posedge clk_i) begin
    if (take_s2 && s1_go) begin
      prod_q    <= prod_d;
      s2_meta_q <= s1_meta_q;
    end
    if (take_s3 && s2_v_q) begin
      for (int r = 0; r < Taps; r++) begin
        rsum_q[r] <= RsW'(prod_q[r*Taps]) + RsW'(prod_q[r*Taps+1]) +
                     RsW'(prod_q[r*Taps+2]);
      end
      s3_meta_q <= s2_meta_q;
    end
    if (take_out && s3_v_q) begin
      sum_q      <= total_c[SumW-1:0];
      out_meta_q <= s3_meta_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_row_o   = out_meta_q.row;
  assign out_col_o   = out_meta_q.col;
  assign last_o      = out_meta_q.last;
  assign sum_o       = sum_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> in_ready_o)
    else $error("input stalled with an empty memory stage");

  a_accept_drains_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_v_q) |-> s1_go)
    else $error("pixel accepted while the memory stage holds its write-back");

  a_emit_reaches_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_emit_q) |=> s2_v_q)
    else $error("result lost between memory stage and product stage");

  a_s2_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !take_s2) |=> s2_v_q)
    else $error("stalled product stage dropped its result");

  a_last_diag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (out_row_o == out_col_o))
    else $error("final result of a frame off the diagonal");

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for conv3x3_valid_stream. Pixels go in through a
// valid/ready driver with random gaps. Each accepted pixel updates an
// in-bench copy of the line buffers, the window and the position counters.
// That copy queues the expected 3x3 sum. A checker compares every result
// transaction with the oldest queued sum. Runs cover the reset kernel over a
// full 256x256 frame, extreme values, side clamping, a side shrink inside a
// frame, a long output hold-off and random frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import c3vs_pkg::*;

  localparam int unsigned MaxSide     = 256;
  localparam int unsigned PixW        = 16;
  localparam int unsigned CoefW       = 8;
  localparam int unsigned SumW        = PixW + CoefW + 3;
  localparam int unsigned CfgDataW    = 3 * CoefW;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned RandomItems = 400;
  localparam longint      TimeoutNs   = 5_000_000;

  localparam logic signed [PixW-1:0] PixMin = {1'b1, {(PixW-1){1'b0}}};
  localparam logic signed [PixW-1:0] PixMax = {1'b0, {(PixW-1){1'b1}}};

  typedef struct {
    logic [OutPosW-1:0]     row;
    logic [OutPosW-1:0]     col;
    logic signed [SumW-1:0] sum;
    logic                   last;
  } conv_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  cfg_idx_e                cfg_idx_i;
  logic [CfgDataW-1:0]     cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [PixW-1:0]  pixel_i;
  logic                    frame_start_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [OutPosW-1:0]      out_row_o;
  logic [OutPosW-1:0]      out_col_o;
  logic signed [SumW-1:0]  sum_o;
  logic                    last_o;

  // in-bench copy of the block state and registers
  logic [SideW-1:0]        side_reg;
  logic [CfgDataW-1:0]     coef_reg [NumTaps];
  logic signed [PixW-1:0]  line_prev [MaxSide];
  logic signed [PixW-1:0]  line_prev2 [MaxSide];
  logic signed [PixW-1:0]  win_px [NumTaps][NumTaps];
  int unsigned             col_pos;
  int unsigned             row_pos;

  conv_result_t            pending_sums [$];

  bit                      in_idle_on;
  bit                      out_idle_on;
  int unsigned             hold_off;
  int unsigned             stall_left;
  int unsigned             n_pixels;
  int unsigned             n_results;
  int unsigned             n_writes;
  int unsigned             n_errors;

  conv3x3_valid_stream #(
    .MAX_SIDE   (MaxSide),
    .PIXEL_BITS (PixW),
    .COEF_BITS  (CoefW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .sum_o         (sum_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic void init_model();
    side_reg    = SideW'(SideRst);
    coef_reg[0] = {3{8'hFF}};
    coef_reg[1] = {8'hFF, 8'(LapCenter), 8'hFF};
    coef_reg[2] = {3{8'hFF}};
    for (int i = 0; i < MaxSide; i++) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    for (int r = 0; r < NumTaps; r++) begin
      for (int k = 0; k < NumTaps; k++) win_px[r][k] = '0;
    end
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic int unsigned eff_side();
    if (side_reg < MinSide) return MinSide;
    if (side_reg > MaxSide) return MaxSide;
    return side_reg;
  endfunction

  function automatic void predict_window_sum(logic signed [PixW-1:0] pix, logic fs);
    int unsigned  n;
    int unsigned  c;
    longint       acc;
    conv_result_t res;
    n = eff_side();
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos % MaxSide;
    for (int r = 0; r < NumTaps; r++) begin
      win_px[r][0] = win_px[r][1];
      win_px[r][1] = win_px[r][2];
    end
    win_px[0][2]  = line_prev2[c];
    win_px[1][2]  = line_prev[c];
    win_px[2][2]  = pix;
    line_prev2[c] = line_prev[c];
    line_prev[c]  = pix;
    if (row_pos >= 2 && col_pos >= 2) begin
      acc = 0;
      for (int r = 0; r < NumTaps; r++) begin
        for (int k = 0; k < NumTaps; k++) begin
          acc += longint'(win_px[r][k]) * longint'($signed(coef_reg[r][CoefW*k +: CoefW]));
        end
      end
      res.row  = OutPosW'(row_pos - 2);
      res.col  = OutPosW'(col_pos - 2);
      res.sum  = acc[SumW-1:0];
      res.last = (row_pos == n - 1) && (col_pos == n - 1);
      pending_sums.push_back(res);
    end
    // counters left past the end by a side shrink wrap at their next advance
    if (col_pos + 1 >= n) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= n) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic logic signed [PixW-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return PixMin;
      1:       return PixMax;
      2:       return PixW'(int'($urandom_range(0, 31)) - 16);
      default: return PixW'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_coefs();
    logic [CfgDataW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = {3{8'h80}};
      1: v = {3{8'h7F}};
      2: begin
        for (int k = 0; k < NumTaps; k++) v[CoefW*k +: CoefW] = CoefW'(int'($urandom_range(0, 8)) - 4);
      end
      default: v = CfgDataW'($urandom);
    endcase
    return v;
  endfunction

  function automatic int unsigned rand_side();
    case ($urandom_range(0, 19))
      0:          return $urandom_range(0, MinSide - 1);
      1:          return $urandom_range(25, 40);
      2, 3, 4, 5: return $urandom_range(9, 24);
      default:    return $urandom_range(MinSide, 8);
    endcase
  endfunction

  task automatic send_pixel(input logic signed [PixW-1:0] pix, input logic fs);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= pix;
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    n_pixels++;
    predict_window_sum(pix, fs);
  endtask

  // pixels that make no result may still be in flight after the last sum
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SIDE) side_reg = val[SideW-1:0];
    else coef_reg[int'(idx) - int'(CFG_COEF_ROW0)] = val;
    n_writes++;
  endtask

  task automatic write_all_coefs(input logic [CfgDataW-1:0] val);
    write_reg(CFG_COEF_ROW0, val);
    write_reg(CFG_COEF_ROW1, val);
    write_reg(CFG_COEF_ROW2, val);
  endtask

  // -------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    n_errors++;
  endtask

  task automatic take_result();
    conv_result_t want;
    if (pending_sums.size() == 0) begin
      report_mismatch($sformatf("result (%0d,%0d) sum %0d with nothing pending",
                                out_row_o, out_col_o, sum_o));
    end else begin
      want = pending_sums.pop_front();
      if (out_row_o !== want.row)
        report_mismatch($sformatf("out_row got %0d, expected %0d", out_row_o, want.row));
      if (out_col_o !== want.col)
        report_mismatch($sformatf("out_col got %0d, expected %0d", out_col_o, want.col));
      if (sum_o !== want.sum)
        report_mismatch($sformatf("sum at (%0d,%0d) got %0d, expected %0d",
                                  want.row, want.col, sum_o, want.sum));
      if (last_o !== want.last)
        report_mismatch($sformatf("last at (%0d,%0d) got %0b, expected %0b",
                                  want.row, want.col, last_o, want.last));
    end
    n_results++;
    stall_left = out_idle_on ? $urandom_range(0, 5) : 0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) take_result();
  end

  // result sink: per-transaction stalls plus an occasional long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- tests

  // reset registers: side 256 and the laplacian kernel, one full frame
  task automatic test_reset_kernel();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    for (int i = 0; i < MaxSide * MaxSide; i++) send_pixel(rand_pixel(), i == 0);
    wait_idle();
  endtask

  task automatic test_extreme_values();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    write_reg(CFG_SIDE, CfgDataW'(MinSide));
    write_all_coefs({3{8'h80}});
    for (int i = 0; i < 9; i++) send_pixel(PixMin, i == 0);
    // no frame start: the counters wrap into a new frame by themselves
    for (int i = 0; i < 9; i++) send_pixel(PixMax, 1'b0);
    wait_idle();
    write_all_coefs({3{8'h7F}});
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? PixMax : PixMin, i == 0);
    wait_idle();
  endtask

  task automatic test_side_clamp();
    write_reg(CFG_SIDE, '0);
    write_all_coefs(rand_coefs());
    for (int i = 0; i < 9; i++) send_pixel(rand_pixel(), i == 0);
    wait_idle();
    write_reg(CFG_SIDE, CfgDataW'(MinSide - 1));
    for (int i = 0; i < 9; i++) send_pixel(rand_pixel(), i == 0);
    wait_idle();
    // above the maximum the row wraps after 256 pixels
    write_reg(CFG_SIDE, CfgDataW'(300));
    for (int i = 0; i < 2 * MaxSide + 10; i++) send_pixel(rand_pixel(), i == 0);
    wait_idle();
  endtask

  // counters sit at row 2, column 10 here; shrinking to 3 wraps both
  task automatic test_shrink_mid_frame();
    write_reg(CFG_SIDE, CfgDataW'(MinSide));
    for (int i = 0; i < 12; i++) send_pixel(rand_pixel(), 1'b0);
    wait_idle();
  endtask

  task automatic test_output_hold_off();
    write_reg(CFG_SIDE, CfgDataW'(6));
    write_reg(CFG_COEF_ROW0, rand_coefs());
    write_reg(CFG_COEF_ROW1, rand_coefs());
    write_reg(CFG_COEF_ROW2, rand_coefs());
    @(posedge clk_i);
    hold_off = HoldCycles;
    for (int i = 0; i < 36; i++) send_pixel(rand_pixel(), i == 0);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned first_pixel;
    int unsigned n;
    int unsigned len;
    int          stray_at;
    bit          fs0;
    first_pixel = n_pixels;
    while (n_pixels - first_pixel < RandomItems) begin
      wait_idle();
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) write_reg(CFG_SIDE, CfgDataW'(rand_side()));
      for (int r = 0; r < NumTaps; r++) begin
        if ($urandom_range(0, 2) == 0)
          write_reg(cfg_idx_e'(int'(CFG_COEF_ROW0) + r), rand_coefs());
      end
      n   = eff_side();
      len = n * n;
      // some frames are cut short, some get a stray frame start
      if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len - 1);
      stray_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, len - 1)) : -1;
      // a frame start may be left out only when the counters are at the origin
      fs0 = !(row_pos == 0 && col_pos == 0) || ($urandom_range(0, 1) != 0);
      for (int i = 0; i < len; i++)
        send_pixel(rand_pixel(), (i == 0 && fs0) || i == stray_at);
    end
    wait_idle();
  endtask

  // ------------------------------------------------------------------ main

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SIDE;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    pixel_i       = '0;
    frame_start_i = 1'b0;
    in_idle_on    = 1'b0;
    out_idle_on   = 1'b0;
    hold_off      = 0;
    stall_left    = 0;
    n_pixels      = 0;
    n_results     = 0;
    n_writes      = 0;
    n_errors      = 0;
    init_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_kernel();
    test_extreme_values();
    test_side_clamp();
    test_shrink_mid_frame();
    test_output_hold_off();
    test_random_frames();

    repeat (DrainCycles) @(posedge clk_i);
    $display("run covered %0d pixels, %0d results and %0d register writes (%0d mismatches)",
             n_pixels, n_results, n_writes, n_errors);
    $display("sides 3 to 256 with clamping, extreme values, a mid-frame shrink and a long hold-off");
    if (n_errors == 0 && pending_sums.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("timeout with %0d results still pending", pending_sums.size());
    $display("Verification failed");
    $finish;
  end

endmodule
